>>> hw/rtl/lcp_pkg.sv
// shared constants and codes for the parametric line clipper
package lcp_pkg;

  // default coordinate width and its legal range
  localparam int COORD_BITS_DEF = 12;
  localparam int COORD_BITS_MIN = 8;
  localparam int COORD_BITS_MAX = 16;

  // configuration register index width
  localparam int CFG_IDX_BITS = 2;

  // window reset values
  localparam int WIN_LEFT_RST   = -100;
  localparam int WIN_RIGHT_RST  = 100;
  localparam int WIN_BOTTOM_RST = -100;
  localparam int WIN_TOP_RST    = 100;

  // configuration register map
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_WIN_LEFT   = 2'd0,
    REG_WIN_RIGHT  = 2'd1,
    REG_WIN_BOTTOM = 2'd2,
    REG_WIN_TOP    = 2'd3
  } cfg_reg_e;

  // stages ahead of the divider and after it
  localparam int PRE_STAGES  = 7;
  localparam int POST_STAGES = 1;

endpackage

>>> hw/rtl/line_clip_parametric_unit.sv
// parametric segment clipper against a configurable rectangle, fully pipelined
// throughput: one item per cycle while the output is not stalled; seven
//   arithmetic stages, a restoring divider of one quotient bit per stage
//   (COORD_BITS stages) and an output register
// stages advance independently, so bubbles close up while the output stalls
// reset clears all valid bits and loads the window to -100..100 on both axes
module line_clip_parametric_unit #(
  parameter int COORD_BITS = lcp_pkg::COORD_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration writes
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [lcp_pkg::CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [COORD_BITS-1:0]             cfg_data_i,
  // segment input
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [COORD_BITS-1:0]      start_x_i,
  input  logic signed [COORD_BITS-1:0]      start_y_i,
  input  logic signed [COORD_BITS-1:0]      end_x_i,
  input  logic signed [COORD_BITS-1:0]      end_y_i,
  // clipped result
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              accepted_o,
  output logic signed [COORD_BITS-1:0]      entry_x_o,
  output logic signed [COORD_BITS-1:0]      entry_y_o,
  output logic signed [COORD_BITS-1:0]      exit_x_o,
  output logic signed [COORD_BITS-1:0]      exit_y_o
);

  localparam int W  = COORD_BITS;
  localparam int NW = W + 1;          // differences and numerators
  localparam int DW = W + 2;          // denominators, kept signed positive
  localparam int PW = NW + DW;        // cross products
  localparam int MW = 2 * W + 2;      // point numerator products
  localparam int SW = MW + 1;         // point numerator sum
  localparam int RW = MW;             // divider remainder magnitude
  localparam int N  = lcp_pkg::PRE_STAGES + W + lcp_pkg::POST_STAGES;
  localparam int DV = lcp_pkg::PRE_STAGES;

  // window registers
  logic signed [W-1:0] win_left_q, win_right_q, win_bottom_q, win_top_q;

  // stage valids and ready chain
  logic [N-1:0] v_q;
  logic [N:0]   rdy;

  // stage 0 comb and regs
  logic signed [NW-1:0] dx_c, dy_c, qxl_c, qxr_c, qyb_c, qyt_c;
  logic signed [W-1:0]  s0_x0_q, s0_y0_q;
  logic signed [NW-1:0] s0_dx_q, s0_dy_q;
  logic signed [NW-1:0] s0_xen_q, s0_xlv_q, s0_yen_q, s0_ylv_q;
  logic signed [DW-1:0] s0_adx_q, s0_ady_q;
  logic                 s0_xpar_q, s0_ypar_q, s0_rej_q;

  // stage 1: per-axis entry and exit fractions
  logic signed [W-1:0]  s1_x0_q, s1_y0_q;
  logic signed [NW-1:0] s1_dx_q, s1_dy_q;
  logic signed [NW-1:0] s1_exn_q, s1_eyn_q, s1_lxn_q, s1_lyn_q;
  logic signed [DW-1:0] s1_exd_q, s1_eyd_q, s1_lxd_q, s1_lyd_q;
  logic                 s1_rej_q;

  // stage 2: axis cross products
  logic signed [W-1:0]  s2_x0_q, s2_y0_q;
  logic signed [NW-1:0] s2_dx_q, s2_dy_q;
  logic signed [NW-1:0] s2_exn_q, s2_eyn_q, s2_lxn_q, s2_lyn_q;
  logic signed [DW-1:0] s2_exd_q, s2_eyd_q, s2_lxd_q, s2_lyd_q;
  logic signed [PW-1:0] s2_pxe_q, s2_pye_q, s2_pxl_q, s2_pyl_q;
  logic                 s2_rej_q;

  // stage 3: selected entry and exit
  logic signed [W-1:0]  s3_x0_q, s3_y0_q;
  logic signed [NW-1:0] s3_dx_q, s3_dy_q;
  logic signed [NW-1:0] s3_en_q, s3_ln_q;
  logic signed [DW-1:0] s3_ed_q, s3_ld_q;
  logic                 s3_rej_q;

  // stage 4: accept products and point numerator products
  logic signed [PW-1:0] s4_acca_q, s4_accb_q;
  logic signed [MW-1:0] s4_pa_q [4];
  logic signed [MW-1:0] s4_pb_q [4];
  logic [DW-2:0]        s4_ed_q, s4_ld_q;
  logic                 s4_rej_q;

  // stage 5: numerator sums and accept flag
  logic signed [SW-1:0] s5_sum_q [4];
  logic [DW-2:0]        s5_ed_q, s5_ld_q;
  logic                 s5_ok_q;

  // divider pipeline, index 0 is the magnitude stage
  logic [RW-1:0] dv_rem_q [W+1][4];
  logic [W-1:0]  dv_quo_q [W+1][4];
  logic [DW-2:0] dv_den_q [W+1][2];
  logic [3:0]    dv_neg_q [W+1];
  logic          dv_ok_q  [W+1];

  // output register
  logic                acc_q;
  logic signed [W-1:0] entry_x_q, entry_y_q, exit_x_q, exit_y_q;

  // configuration port
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_left_q   <= W'(lcp_pkg::WIN_LEFT_RST);
      win_right_q  <= W'(lcp_pkg::WIN_RIGHT_RST);
      win_bottom_q <= W'(lcp_pkg::WIN_BOTTOM_RST);
      win_top_q    <= W'(lcp_pkg::WIN_TOP_RST);
    end else if (cfg_valid_i) begin
      unique case (lcp_pkg::cfg_reg_e'(cfg_index_i))
        lcp_pkg::REG_WIN_LEFT:   win_left_q   <= cfg_data_i;
        lcp_pkg::REG_WIN_RIGHT:  win_right_q  <= cfg_data_i;
        lcp_pkg::REG_WIN_BOTTOM: win_bottom_q <= cfg_data_i;
        lcp_pkg::REG_WIN_TOP:    win_top_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ready chain: a stage moves when it is empty or the next one moves
  assign rdy[N] = out_ready_i;
  for (genvar k = 0; k < N; k++) begin : g_rdy
    assign rdy[k] = !v_q[k] || rdy[k+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int k = 1; k < N; k++) begin
        if (rdy[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[N-1];

  // stage 0: deltas and edge distances
  assign dx_c  = NW'(end_x_i) - NW'(start_x_i);
  assign dy_c  = NW'(end_y_i) - NW'(start_y_i);
  assign qxl_c = NW'(start_x_i) - NW'(win_left_q);
  assign qxr_c = NW'(win_right_q) - NW'(start_x_i);
  assign qyb_c = NW'(start_y_i) - NW'(win_bottom_q);
  assign qyt_c = NW'(win_top_q) - NW'(start_y_i);

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      s0_x0_q   <= start_x_i;
      s0_y0_q   <= start_y_i;
      s0_dx_q   <= dx_c;
      s0_dy_q   <= dy_c;
      s0_adx_q  <= (dx_c < 0) ? -DW'(dx_c) : DW'(dx_c);
      s0_ady_q  <= (dy_c < 0) ? -DW'(dy_c) : DW'(dy_c);
      s0_xen_q  <= (dx_c > 0) ? -qxl_c : -qxr_c;
      s0_xlv_q  <= (dx_c > 0) ? qxr_c : qxl_c;
      s0_yen_q  <= (dy_c > 0) ? -qyb_c : -qyt_c;
      s0_ylv_q  <= (dy_c > 0) ? qyt_c : qyb_c;
      s0_xpar_q <= (dx_c == 0);
      s0_ypar_q <= (dy_c == 0);
      // a parallel axis with the start outside rejects the segment
      s0_rej_q  <= ((dx_c == 0) && (qxl_c < 0 || qxr_c < 0)) ||
                   ((dy_c == 0) && (qyb_c < 0 || qyt_c < 0));
    end
  end

  // stage 1: clamp each axis against the start values 0 and 1
  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      s1_x0_q  <= s0_x0_q;
      s1_y0_q  <= s0_y0_q;
      s1_dx_q  <= s0_dx_q;
      s1_dy_q  <= s0_dy_q;
      s1_rej_q <= s0_rej_q;
      if (!s0_xpar_q && s0_xen_q > 0) begin
        s1_exn_q <= s0_xen_q;
        s1_exd_q <= s0_adx_q;
      end else begin
        s1_exn_q <= '0;
        s1_exd_q <= DW'(1);
      end
      if (!s0_xpar_q && DW'(s0_xlv_q) < s0_adx_q) begin
        s1_lxn_q <= s0_xlv_q;
        s1_lxd_q <= s0_adx_q;
      end else begin
        s1_lxn_q <= NW'(1);
        s1_lxd_q <= DW'(1);
      end
      if (!s0_ypar_q && s0_yen_q > 0) begin
        s1_eyn_q <= s0_yen_q;
        s1_eyd_q <= s0_ady_q;
      end else begin
        s1_eyn_q <= '0;
        s1_eyd_q <= DW'(1);
      end
      if (!s0_ypar_q && DW'(s0_ylv_q) < s0_ady_q) begin
        s1_lyn_q <= s0_ylv_q;
        s1_lyd_q <= s0_ady_q;
      end else begin
        s1_lyn_q <= NW'(1);
        s1_lyd_q <= DW'(1);
      end
    end
  end

  // stage 2: cross products to compare x and y fractions
  always_ff @(posedge clk_i) begin
    if (rdy[2]) begin
      s2_x0_q  <= s1_x0_q;
      s2_y0_q  <= s1_y0_q;
      s2_dx_q  <= s1_dx_q;
      s2_dy_q  <= s1_dy_q;
      s2_rej_q <= s1_rej_q;
      s2_exn_q <= s1_exn_q;
      s2_eyn_q <= s1_eyn_q;
      s2_lxn_q <= s1_lxn_q;
      s2_lyn_q <= s1_lyn_q;
      s2_exd_q <= s1_exd_q;
      s2_eyd_q <= s1_eyd_q;
      s2_lxd_q <= s1_lxd_q;
      s2_lyd_q <= s1_lyd_q;
      s2_pxe_q <= PW'(s1_exn_q) * PW'(s1_eyd_q);
      s2_pye_q <= PW'(s1_eyn_q) * PW'(s1_exd_q);
      s2_pxl_q <= PW'(s1_lxn_q) * PW'(s1_lyd_q);
      s2_pyl_q <= PW'(s1_lyn_q) * PW'(s1_lxd_q);
    end
  end

  // stage 3: latest entry and earliest exit
  always_ff @(posedge clk_i) begin
    if (rdy[3]) begin
      s3_x0_q  <= s2_x0_q;
      s3_y0_q  <= s2_y0_q;
      s3_dx_q  <= s2_dx_q;
      s3_dy_q  <= s2_dy_q;
      s3_rej_q <= s2_rej_q;
      if (s2_pye_q > s2_pxe_q) begin
        s3_en_q <= s2_eyn_q;
        s3_ed_q <= s2_eyd_q;
      end else begin
        s3_en_q <= s2_exn_q;
        s3_ed_q <= s2_exd_q;
      end
      if (s2_pyl_q < s2_pxl_q) begin
        s3_ln_q <= s2_lyn_q;
        s3_ld_q <= s2_lyd_q;
      end else begin
        s3_ln_q <= s2_lxn_q;
        s3_ld_q <= s2_lxd_q;
      end
    end
  end

  // stage 4: accept test products and start*d, n*delta for all four points
  always_ff @(posedge clk_i) begin
    if (rdy[4]) begin
      s4_rej_q   <= s3_rej_q;
      s4_ed_q    <= s3_ed_q[DW-2:0];
      s4_ld_q    <= s3_ld_q[DW-2:0];
      s4_acca_q  <= PW'(s3_en_q) * PW'(s3_ld_q);
      s4_accb_q  <= PW'(s3_ln_q) * PW'(s3_ed_q);
      s4_pa_q[0] <= MW'(s3_x0_q) * MW'(s3_ed_q);
      s4_pb_q[0] <= MW'(s3_en_q) * MW'(s3_dx_q);
      s4_pa_q[1] <= MW'(s3_y0_q) * MW'(s3_ed_q);
      s4_pb_q[1] <= MW'(s3_en_q) * MW'(s3_dy_q);
      s4_pa_q[2] <= MW'(s3_x0_q) * MW'(s3_ld_q);
      s4_pb_q[2] <= MW'(s3_ln_q) * MW'(s3_dx_q);
      s4_pa_q[3] <= MW'(s3_y0_q) * MW'(s3_ld_q);
      s4_pb_q[3] <= MW'(s3_ln_q) * MW'(s3_dy_q);
    end
  end

  // stage 5: accept flag and point numerators
  always_ff @(posedge clk_i) begin
    if (rdy[5]) begin
      s5_ok_q <= !s4_rej_q && !(s4_acca_q > s4_accb_q);
      s5_ed_q <= s4_ed_q;
      s5_ld_q <= s4_ld_q;
      for (int c = 0; c < 4; c++) begin
        s5_sum_q[c] <= SW'(s4_pa_q[c]) + SW'(s4_pb_q[c]);
      end
    end
  end

  // stage 6: sign and magnitude into the divider
  always_ff @(posedge clk_i) begin
    if (rdy[6]) begin
      dv_ok_q[0]     <= s5_ok_q;
      dv_den_q[0][0] <= s5_ed_q;
      dv_den_q[0][1] <= s5_ld_q;
      for (int c = 0; c < 4; c++) begin
        dv_neg_q[0][c] <= s5_sum_q[c][SW-1];
        dv_rem_q[0][c] <= s5_sum_q[c][SW-1] ? RW'(-s5_sum_q[c]) : RW'(s5_sum_q[c]);
        dv_quo_q[0][c] <= '0;
      end
    end
  end

  // restoring divider, one quotient bit per stage from the top
  for (genvar j = 0; j < W; j++) begin : g_div
    localparam int B = W - 1 - j;
    logic [RW-1:0] shf    [4];
    logic [RW-1:0] rem_nx [4];
    logic [W-1:0]  quo_nx [4];

    always_comb begin
      for (int c = 0; c < 4; c++) begin
        shf[c] = RW'((c < 2) ? dv_den_q[j][0] : dv_den_q[j][1]) << B;
        if (dv_rem_q[j][c] >= shf[c]) begin
          rem_nx[c] = dv_rem_q[j][c] - shf[c];
          quo_nx[c] = dv_quo_q[j][c] | (W'(1) << B);
        end else begin
          rem_nx[c] = dv_rem_q[j][c];
          quo_nx[c] = dv_quo_q[j][c];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[DV+j]) begin
        dv_rem_q[j+1] <= rem_nx;
        dv_quo_q[j+1] <= quo_nx;
        dv_den_q[j+1] <= dv_den_q[j];
        dv_neg_q[j+1] <= dv_neg_q[j];
        dv_ok_q[j+1]  <= dv_ok_q[j];
      end
    end
  end

  // output register: restore sign, zero on rejection
  always_ff @(posedge clk_i) begin
    if (rdy[N-1]) begin
      acc_q     <= dv_ok_q[W];
      entry_x_q <= !dv_ok_q[W] ? '0 :
                   dv_neg_q[W][0] ? W'(-dv_quo_q[W][0]) : dv_quo_q[W][0];
      entry_y_q <= !dv_ok_q[W] ? '0 :
                   dv_neg_q[W][1] ? W'(-dv_quo_q[W][1]) : dv_quo_q[W][1];
      exit_x_q  <= !dv_ok_q[W] ? '0 :
                   dv_neg_q[W][2] ? W'(-dv_quo_q[W][2]) : dv_quo_q[W][2];
      exit_y_q  <= !dv_ok_q[W] ? '0 :
                   dv_neg_q[W][3] ? W'(-dv_quo_q[W][3]) : dv_quo_q[W][3];
    end
  end

  assign accepted_o = acc_q;
  assign entry_x_o  = entry_x_q;
  assign entry_y_o  = entry_y_q;
  assign exit_x_o   = exit_x_q;
  assign exit_y_o   = exit_y_q;

endmodule

>>> hw/rtl/lcp_checker.sv
// port-level checks for the parametric line clipper, bound to the top level
module lcp_checker #(
  parameter int COORD_BITS = lcp_pkg::COORD_BITS_DEF
) (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              cfg_valid_i,
  input logic                              cfg_ready_o,
  input logic [lcp_pkg::CFG_IDX_BITS-1:0]  cfg_index_i,
  input logic [COORD_BITS-1:0]             cfg_data_i,
  input logic                              in_valid_i,
  input logic                              in_ready_o,
  input logic signed [COORD_BITS-1:0]      start_x_i,
  input logic signed [COORD_BITS-1:0]      start_y_i,
  input logic signed [COORD_BITS-1:0]      end_x_i,
  input logic signed [COORD_BITS-1:0]      end_y_i,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic                              accepted_o,
  input logic signed [COORD_BITS-1:0]      entry_x_o,
  input logic signed [COORD_BITS-1:0]      entry_y_o,
  input logic signed [COORD_BITS-1:0]      exit_x_o,
  input logic signed [COORD_BITS-1:0]      exit_y_o
);

  // a stalled result holds its valid and payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(accepted_o) &&
    $stable(entry_x_o) && $stable(entry_y_o) && $stable(exit_x_o) && $stable(exit_y_o))
    else $error("stalled result changed");

  // a rejected item carries zero points
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !accepted_o |->
    entry_x_o == '0 && entry_y_o == '0 && exit_x_o == '0 && exit_y_o == '0)
    else $error("rejected item with nonzero points");

  // input backpressure only when the whole pipe is full behind a stalled output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled while the pipeline could move");

  // an output that is empty now and was empty before leaves the input ready
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(!out_valid_o) && !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output");

endmodule

bind line_clip_parametric_unit lcp_checker #(.COORD_BITS(COORD_BITS)) u_lcp_checker (.*);
